### hdl/hbps_pkg.sv
// ----------------------------------------------------------------------------
// hbps_pkg
// Shared types and constants for the histogram bit-plane sums engine.
// ----------------------------------------------------------------------------
package hbps_pkg;

  localparam int unsigned VALUE_BITS_DEF  = 16;
  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam int unsigned SAMPLE_W        = 16;
  localparam int unsigned REQ_W           = 2;
  localparam int unsigned SUM_W           = 48;
  localparam int unsigned NUM_POS         = 16;
  localparam int unsigned POS_W           = 4;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Request codes
  localparam logic [REQ_W-1:0] REQ_COUNT  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REPORT = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [SAMPLE_W-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] bit_index;
    logic [SUM_W-1:0] bit_sum;
    logic             last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_WALK,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_req;
    logic addr_clear;
    logic addr_step;
    logic zero_we;
    logic cnt_rd;
    logic cnt_we;
    logic walk_rd;
    logic acc_clear;
    logic pos_clear;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic addr_last;
    logic pos_last;
  } sts_t;

endpackage

### hdl/histogram_bit_plane_sums_top.sv
// ----------------------------------------------------------------------------
// histogram_bit_plane_sums_top
// Histogram engine that counts samples into bins and reports bit-plane sums.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every request goes
// through the single-port-per-side bin store (2**VALUE_BITS entries), so busy
// stays high while one runs. After reset the block clears the store first and
// holds busy until that sweep is done. A count request reads the bin, then
// writes it back. A clear request sweeps the store at one bin per cycle. A
// report request reads one bin per cycle into sixteen accumulators, then
// sends sixteen results, one per cycle, bit 0 first; busy stays high through
// the last send, and the last result appears in the cycle in which busy
// falls. Results are shown for one cycle with res_valid_o and cannot be held
// off, so the receiver must take them as they come. Request code 3 is
// dropped.
module histogram_bit_plane_sums_top
  import hbps_pkg::*;
#(
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  req_i,
  output logic      res_valid_o,
  output out_item_t res_o
);

  cmd_t cmd;
  sts_t sts;

  hbps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_i.req_type),
    .busy       (busy),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  hbps_dp #(
    .VALUE_BITS  (VALUE_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_value_i (req_i.sample_value),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .res_valid_o    (res_valid_o),
    .res_o          (res_o)
  );

endmodule

### hdl/hbps_ram.sv
// ----------------------------------------------------------------------------
// hbps_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hbps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/hbps_ctrl.sv
// ----------------------------------------------------------------------------
// hbps_ctrl
// Request sequencer: count, clear pass, and report walk/emit.
// ----------------------------------------------------------------------------
module hbps_ctrl
  import hbps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic [REQ_W-1:0] req_type_i,
  output logic             busy,
  output cmd_t             cmd_o,
  input  sts_t             sts_i
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // the store is swept to zero right after reset
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load_req = 1'b1;
          case (req_type_i)
            REQ_COUNT: begin
              state_d = ST_CNT_RD;
            end
            REQ_CLEAR: begin
              cmd_o.addr_clear = 1'b1;
              state_d          = ST_CLEAR;
            end
            REQ_REPORT: begin
              cmd_o.addr_clear = 1'b1;
              cmd_o.acc_clear  = 1'b1;
              cmd_o.pos_clear  = 1'b1;
              state_d          = ST_WALK;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        cmd_o.zero_we   = 1'b1;
        cmd_o.addr_step = 1'b1;
        if (sts_i.addr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_CNT_RD: begin
        cmd_o.cnt_rd = 1'b1;
        state_d      = ST_CNT_WR;
      end
      ST_CNT_WR: begin
        cmd_o.cnt_we = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_WALK: begin
        cmd_o.walk_rd   = 1'b1;
        cmd_o.addr_step = 1'b1;
        if (sts_i.addr_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last bin's read data lands in the accumulators this cycle
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.pos_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  a_emit_ends_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit && sts_i.pos_last |=> state_q == ST_IDLE)
    else $error("report did not end after the last position");

  a_no_write_in_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK || state_q == ST_DRAIN || state_q == ST_EMIT)
      |-> !(cmd_o.zero_we || cmd_o.cnt_we))
    else $error("store written during report");

endmodule

### hdl/hbps_dp.sv
// ----------------------------------------------------------------------------
// hbps_dp
// Datapath: bin store, address and position counters, bit-plane accumulators
// and the result register.
// ----------------------------------------------------------------------------
module hbps_dp
  import hbps_pkg::*;
#(
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [SAMPLE_W-1:0] sample_value_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic                res_valid_o,
  output out_item_t           res_o
);

  localparam int unsigned NUM_BINS = 1 << VALUE_BITS;
  localparam int unsigned ADD_W    = ((COUNT_WIDTH > SUM_W) ? COUNT_WIDTH : SUM_W) + 1;
  localparam logic [ADD_W-1:0] SUM_LIMIT = ADD_W'(SUM_MAX);

  logic [VALUE_BITS-1:0]  bin_q;
  logic [VALUE_BITS-1:0]  addr_q;
  logic [VALUE_BITS-1:0]  idx_q;
  logic                   rd_vld_q;
  logic [POS_W-1:0]       pos_q;
  logic [SUM_W-1:0]       acc_q [NUM_POS];
  logic [SUM_W-1:0]       acc_d [NUM_POS];
  logic                   res_valid_q;
  out_item_t              res_q;

  logic                   mem_we;
  logic [VALUE_BITS-1:0]  mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;
  logic [VALUE_BITS-1:0]  mem_raddr;
  logic [COUNT_WIDTH-1:0] mem_rdata;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [NUM_POS-1:0]     idx_ext;

  // Saturating increment of the bin just read
  assign cnt_inc   = (&mem_rdata) ? mem_rdata : mem_rdata + COUNT_WIDTH'(1);
  assign mem_we    = cmd_i.zero_we | cmd_i.cnt_we;
  assign mem_waddr = cmd_i.cnt_we ? bin_q : addr_q;
  assign mem_wdata = cmd_i.cnt_we ? cnt_inc : '0;
  assign mem_raddr = cmd_i.cnt_rd ? bin_q : addr_q;

  hbps_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_BINS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (cmd_i.cnt_rd | cmd_i.walk_rd),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      bin_q <= sample_value_i[VALUE_BITS-1:0];
    end
    idx_q <= addr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      pos_q       <= '0;
      rd_vld_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cmd_i.addr_clear) begin
        addr_q <= '0;
      end else if (cmd_i.addr_step) begin
        addr_q <= addr_q + VALUE_BITS'(1);
      end
      if (cmd_i.pos_clear) begin
        pos_q <= '0;
      end else if (cmd_i.emit) begin
        pos_q <= pos_q + POS_W'(1);
      end
      rd_vld_q    <= cmd_i.walk_rd;
      res_valid_q <= cmd_i.emit;
    end
  end

  assign idx_ext = NUM_POS'(idx_q);

  // One saturating adder per bit position; all positions update in parallel
  always_comb begin
    logic [ADD_W-1:0] sum;
    for (int k = 0; k < NUM_POS; k++) begin
      sum      = ADD_W'(acc_q[k]) + ADD_W'(mem_rdata);
      acc_d[k] = acc_q[k];
      if (cmd_i.acc_clear) begin
        acc_d[k] = '0;
      end else if (cmd_i.emit) begin
        // shift toward position zero, which feeds the result register
        acc_d[k] = (k < NUM_POS - 1) ? acc_q[(k + 1) % NUM_POS] : '0;
      end else if (rd_vld_q && idx_ext[k]) begin
        acc_d[k] = (sum > SUM_LIMIT) ? SUM_MAX : sum[SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_POS; k++) begin
      acc_q[k] <= acc_d[k];
    end
    if (cmd_i.emit) begin
      res_q.bit_index <= pos_q;
      res_q.bit_sum   <= acc_q[0];
      res_q.last      <= &pos_q;
    end
  end

  assign sts_o.addr_last = &addr_q;
  assign sts_o.pos_last  = &pos_q;
  assign res_valid_o     = res_valid_q;
  assign res_o           = res_q;

  a_last_is_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.last |-> res_q.bit_index == POS_W'(NUM_POS - 1))
    else $error("last marker on wrong position");

  a_results_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.bit_index != '0 |-> $past(res_valid_q))
    else $error("gap inside a report");

  a_no_emit_while_accum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> !cmd_i.emit)
    else $error("emit overlaps accumulation");

endmodule
